/* design/window_rms_level_meter_top_assert.svh */
// assertion macros of the window rms level meter, used by its controller
`ifndef WINDOW_RMS_LEVEL_METER_TOP_ASSERT_SVH
`define WINDOW_RMS_LEVEL_METER_TOP_ASSERT_SVH

// same-cycle implication, checked on clk, idle during reset
`define WRMS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wrms assertion failed");

// next-cycle implication, checked on clk, idle during reset
`define WRMS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wrms assertion failed");

`endif

/* design/wrms_pkg.sv */
// shared types and constants of the window rms level meter
`default_nettype none

package wrms_pkg;

  localparam int SAMPLE_W         = 16;
  localparam int LEVEL_W          = 32;
  localparam int WLEN_W           = 16;
  localparam int SCALE_W          = 32;
  localparam int SUM_W            = 46;
  localparam int SQ_W             = 31;
  localparam int ROOT_W           = 16;
  localparam int RAD_W            = 32;
  localparam int PROD_W           = ROOT_W + SCALE_W;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 32;
  localparam int FULL_SCALE_SHIFT = 15;
  localparam int ROOT_START_BIT   = 30;
  localparam int DIV_STEPS        = SUM_W;
  localparam int ROOT_STEPS       = 16;
  localparam int STEP_W           = 6;

  localparam logic [WLEN_W-1:0]  WLEN_RESET  = WLEN_W'(480);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(32768);
  localparam logic [STEP_W-1:0]  DIV_LAST    = STEP_W'(DIV_STEPS - 1);
  localparam logic [STEP_W-1:0]  ROOT_LAST   = STEP_W'(ROOT_STEPS - 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LENGTH = 1'b0,
    REG_LEVEL_SCALE   = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DIV,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_MUL,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic acc;
    logic load;
    logic div_step;
    logic root_init;
    logic root_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

/* design/wrms_sample_if.sv */
// sample channel interface
`default_nettype none

interface wrms_sample_if;
  import wrms_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

/* design/wrms_level_if.sv */
// level result channel interface
`default_nettype none

interface wrms_level_if;
  import wrms_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;

  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

/* design/wrms_cfg_if.sv */
// configuration write channel interface
`default_nettype none

interface wrms_cfg_if;
  import wrms_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* design/wrms_dp.sv */
// datapath: accumulator, serial divider, serial square root, scaler, output register
`default_nettype none

module wrms_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [wrms_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                cfg_valid,
  input  logic [wrms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wrms_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wrms_pkg::cmd_t                      cmd,
  output wrms_pkg::sts_t                      sts,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [wrms_pkg::LEVEL_W-1:0]        out_level
);
  import wrms_pkg::*;

  logic [WLEN_W-1:0]  wlen_r;
  logic [SCALE_W-1:0] scale_r;
  logic [SQ_W-1:0]    sq_r;
  logic               pend_r;
  logic [SUM_W-1:0]   sum_r;
  logic [WLEN_W-1:0]  cnt_r;
  logic [WLEN_W-1:0]  div_r;
  logic [SUM_W-1:0]   dvd_r;
  logic [WLEN_W-1:0]  rem_r;
  logic [RAD_W-1:0]   val_r;
  logic [RAD_W-1:0]   root_r;
  logic [RAD_W-1:0]   bit_r;
  logic [PROD_W-1:0]  prod_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;

  logic signed [2*SAMPLE_W-1:0] sq_full;
  logic [WLEN_W-1:0]            cnt_inc;
  logic [WLEN_W-1:0]            limit;
  logic                         close;
  logic [SUM_W-1:0]             sum_add;
  logic [WLEN_W:0]              rem_sh;
  logic [WLEN_W:0]              rem_diff;
  logic                         rem_ge;
  logic [RAD_W-1:0]             trial;
  logic                         take;

  assign sq_full  = in_sample * in_sample;
  assign cnt_inc  = cnt_r + 1'b1;
  assign limit    = (wlen_r == '0) ? WLEN_W'(1) : wlen_r;
  assign close    = (cnt_inc != '0) && (cnt_inc >= limit);
  assign sum_add  = sum_r + (pend_r ? {{(SUM_W-SQ_W){1'b0}}, sq_r} : '0);
  assign rem_sh   = {rem_r, dvd_r[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, div_r};
  assign rem_ge   = rem_sh >= {1'b0, div_r};
  assign trial    = root_r + bit_r;
  assign take     = val_r >= trial;

  assign sts.close    = close;
  assign sts.out_free = !out_valid_r || out_ready;
  assign out_valid    = out_valid_r;
  assign out_level    = out_level_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r  <= WLEN_RESET;
      scale_r <= SCALE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_LENGTH: wlen_r  <= cfg_data[WLEN_W-1:0];
        REG_LEVEL_SCALE:   scale_r <= cfg_data[SCALE_W-1:0];
      endcase
    end
  end

  // accumulation
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else begin
      pend_r <= cmd.acc;
      if (cmd.load) begin
        sum_r <= '0;
      end else begin
        sum_r <= sum_add;
      end
      if (cmd.acc) begin
        cnt_r <= close ? '0 : cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      sq_r <= sq_full[SQ_W-1:0];
      if (close) begin
        div_r <= cnt_inc;
      end
    end
  end

  // restoring divider, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dvd_r <= sum_add;
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? rem_diff[WLEN_W-1:0] : rem_sh[WLEN_W-1:0];
      dvd_r <= {dvd_r[SUM_W-2:0], rem_ge};
    end
  end

  // square root, one root bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      val_r  <= dvd_r[RAD_W-1:0];
      root_r <= '0;
      bit_r  <= RAD_W'(1) << ROOT_START_BIT;
    end else if (cmd.root_step) begin
      if (take) begin
        val_r  <= val_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      prod_r <= root_r[ROOT_W-1:0] * scale_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_level_r <= prod_r[FULL_SCALE_SHIFT +: LEVEL_W];
    end
  end

endmodule

`default_nettype wire

/* design/wrms_ctrl.sv */
// controller: sequences accumulation, divide, root, scale and output load
`default_nettype none
`include "window_rms_level_meter_top_assert.svh"

module wrms_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output wrms_pkg::cmd_t cmd,
  input  wrms_pkg::sts_t sts
);
  import wrms_pkg::*;

  state_t            state_r;
  state_t            state_nxt;
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc = 1'b1;
          if (sts.close) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        cmd.load  = 1'b1;
        step_nxt  = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == DIV_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_ROOT_INIT;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_ROOT_INIT: begin
        cmd.root_init = 1'b1;
        step_nxt      = '0;
        state_nxt     = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (step_r == ROOT_LAST) begin
          step_nxt  = '0;
          state_nxt = ST_MUL;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  `WRMS_ASSERT_NEXT(a_close_flush, (state_r == ST_IDLE) && in_valid && sts.close, state_r == ST_FLUSH)
  `WRMS_ASSERT_NEXT(a_div_len, (state_r == ST_DIV) && (step_r == DIV_LAST), state_r == ST_ROOT_INIT)
  `WRMS_ASSERT_IMPL(a_step_range, (state_r == ST_DIV) || (state_r == ST_ROOT), (step_r <= DIV_LAST) && ((state_r == ST_DIV) || (step_r <= ROOT_LAST)))

endmodule

`default_nettype wire

/* design/window_rms_level_meter_top.sv */
// top level of the windowed rms level meter
//
// in_ch carries signed 16-bit samples, out_ch one unsigned 32-bit level per
// window, cfg_ch register writes (index 0 window length, 1 level scale).
// cfg_ch is always ready; write it only while the meter is idle.
// samples are taken while the meter is idle, so samples that do not close
// a window stream at one per cycle. the sample that closes a window holds
// in_ch off while the meter folds in the last square, does the bit-serial
// divide of the sum by the sample count, sets up and runs the bit-serial
// square root, does the scaling multiply and loads the output register.
// the level appears on out_ch once the output register is loaded.
// the output register lets sampling go on while a level waits; if a level
// is still untaken when the next window closes, the meter holds in the
// output load step until out_ch takes it.
// synchronous reset clears the sum and count, empties the output register
// and restores window length 480 and level scale 32768.
`default_nettype none

module window_rms_level_meter_top (
  input  logic        clk,
  input  logic        rst_n,
  wrms_sample_if.sink in_ch,
  wrms_level_if.source out_ch,
  wrms_cfg_if.sink    cfg_ch
);
  import wrms_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  wrms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  wrms_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_sample (in_ch.sample),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_level (out_ch.level)
  );

endmodule

`default_nettype wire

/* test/tb.sv */
// self-checking testbench of the windowed rms level meter
`timescale 1ns / 100ps

module tb;
  import wrms_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1250;
  localparam int BIG_WINDOW = 240;

  class level_scoreboard;
    logic [WLEN_W-1:0]  wlen;
    logic [SCALE_W-1:0] scale;
    logic [SUM_W-1:0]   sum_sq;
    logic [WLEN_W-1:0]  count;
    logic [LEVEL_W-1:0] levels_due[$];
    int                 errors;

    function new();
      wlen = WLEN_RESET;
      scale = SCALE_RESET;
      sum_sq = '0;
      count = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_WINDOW_LENGTH: wlen = d[WLEN_W-1:0];
        REG_LEVEL_SCALE: scale = d[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ROOT_W:0] isqrt(logic [63:0] v);
      logic [ROOT_W:0] r;
      logic [ROOT_W:0] trial;
      r = '0;
      for (int b = ROOT_W; b >= 0; b--) begin
        trial = r | (17'd1 << b);
        if (64'(trial) * 64'(trial) <= v) r = trial;
      end
      return r;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] s);
      int            v;
      logic [63:0]   mag;
      logic [WLEN_W-1:0] lim;
      logic [63:0]   mean;
      logic [63:0]   prod;
      v = s;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      sum_sq = SUM_W'(64'(sum_sq) + mag * mag);
      count = count + 1'b1;
      lim = (wlen == '0) ? WLEN_W'(1) : wlen;
      if (count < lim || count == '0) return;
      mean = 64'(sum_sq) / 64'(count);
      prod = 64'(isqrt(mean)) * 64'(scale);
      levels_due = {levels_due, LEVEL_W'(prod >> FULL_SCALE_SHIFT)};
      sum_sq = '0;
      count = '0;
    endfunction

    function void check_level(logic [LEVEL_W-1:0] got);
      logic [LEVEL_W-1:0] want;
      if (levels_due.size() == 0) begin
        $display("%0t: unexpected level, expected none actual %0d", $time, got);
        errors++;
        return;
      end
      want = levels_due.pop_front();
      if (got !== want) begin
        $display("%0t: level mismatch, expected %0d actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return levels_due.size();
    endfunction

    function void report_leftover();
      if (levels_due.size() != 0) begin
        $display("%0t: %0d levels never arrived, expected %0d actual none", $time,
                 levels_due.size(), levels_due[0]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   long_hold;
  bit   tx_calm;
  bit   rx_calm;
  bit   tx_no_gaps;
  int   rx_stall;
  level_scoreboard sb = new();

  wrms_sample_if in_if();
  wrms_level_if  out_if();
  wrms_cfg_if    cfg_if();

  window_rms_level_meter_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_if.valid && cfg_if.ready) sb.write_reg(cfg_reg_t'(cfg_if.index), cfg_if.data);
      if (in_if.valid && in_if.ready) sb.note_sample(in_if.sample);
      if (out_if.valid && out_if.ready) sb.check_level(out_if.level);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : -16'($urandom_range(0, 15));
      3: return '0;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [SCALE_W-1:0] pick_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return SCALE_RESET;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [WLEN_W-1:0] pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 16) return WLEN_W'(1);
    if (r < 85) return WLEN_W'($urandom_range(2, 16));
    return WLEN_W'($urandom_range(17, 600));
  endfunction

  // receiver: random stalls, calm stretches and one long hold-off on request
  initial begin
    out_if.ready = 1'b0;
    rx_stall = 0;
    rx_calm = 1'b0;
    long_hold = 0;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
      if (long_hold > 0) begin
        out_if.ready <= 1'b0;
        long_hold--;
      end else if (rx_stall > 0) begin
        out_if.ready <= 1'b0;
        rx_stall--;
      end else begin
        out_if.ready <= 1'b1;
        if (!rx_calm && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
      end
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int g;
    if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
    g = (tx_calm || tx_no_gaps) ? 0 : pick_gap();
    if (g > 0) begin
      in_if.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.sample <= s;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= d;
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic configure(input logic [WLEN_W-1:0] wlen, input logic [SCALE_W-1:0] scale);
    write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(wlen));
    write_reg(REG_LEVEL_SCALE, scale);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_length(input logic [WLEN_W-1:0] wlen);
    write_reg(REG_WINDOW_LENGTH, CFG_DATA_W'(wlen));
    cfg_if.valid <= 1'b0;
  endtask

  // wait for every level in flight, then let the meter go quiet
  task automatic settle();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int sent;
    int n;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    tx_calm = 1'b0;
    tx_no_gaps = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero length acts as one with full scale factor, then length one with zero and unit scale
    configure('0, '1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    send_sample(16'sh0000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    settle();
    configure(WLEN_W'(1), '0);
    send_sample(16'sh8000);
    settle();
    configure(WLEN_W'(1), 32'd1);
    send_sample(16'sh8000);
    send_sample(16'sh7fff);
    settle();

    // length shortened below the count, then lengthened, mid-window
    configure(WLEN_W'(10), SCALE_RESET);
    repeat (6) send_sample(pick_sample());
    settle();
    set_length(WLEN_W'(4));
    send_sample(pick_sample());
    repeat (2) send_sample(pick_sample());
    settle();
    set_length(WLEN_W'(6));
    repeat (4) send_sample(pick_sample());
    settle();

    // long window, near full-scale content
    configure(WLEN_W'(BIG_WINDOW), '1);
    tx_no_gaps = 1'b1;
    repeat (BIG_WINDOW) send_sample($urandom_range(0, 3) == 0 ? pick_sample() : 16'sh8000);
    tx_no_gaps = 1'b0;
    settle();

    // receiver holds off while one-sample windows keep closing
    configure(WLEN_W'(1), pick_scale());
    long_hold = 400;
    sent = 0;
    repeat (10) begin
      send_sample(pick_sample());
      sent++;
    end
    settle();

    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) set_length(pick_length());
      else configure(pick_length(), pick_scale());
      n = $urandom_range(20, 120);
      repeat (n) send_sample(pick_sample());
      sent += n;
      settle();
    end

    sb.report_leftover();
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
